// File: design/sqltl_pkg.sv
// ----------------------------------------------------------------------------
// sqltl_pkg
// Shared types, token kind codes and keyword table of the SQL token lexer.
// ----------------------------------------------------------------------------
package sqltl_pkg;

    localparam int KIND_W   = 6;
    localparam int NUM_KW   = 25;
    localparam int KW_MAX   = 6;
    localparam int KW_BUF_W = 8 * KW_MAX;

    localparam logic [KIND_W-1:0] K_EOF    = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd1;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd2;
    localparam logic [KIND_W-1:0] K_STRING = 6'd3;
    localparam logic [KIND_W-1:0] K_KW0    = 6'd4;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd29;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd30;
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd31;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd32;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd33;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd34;
    localparam logic [KIND_W-1:0] K_EQ     = 6'd35;
    localparam logic [KIND_W-1:0] K_NE     = 6'd36;
    localparam logic [KIND_W-1:0] K_LT     = 6'd37;
    localparam logic [KIND_W-1:0] K_GT     = 6'd38;
    localparam logic [KIND_W-1:0] K_LE     = 6'd39;
    localparam logic [KIND_W-1:0] K_GE     = 6'd40;
    localparam logic [KIND_W-1:0] K_ERROR  = 6'd41;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // text literals, right-justified with the first letter in the highest used byte
    localparam logic [KW_BUF_W-1:0] KW_STR [NUM_KW] = '{
        "SELECT", "FROM", "WHERE", "AND", "OR", "ORDER", "BY", "ASC", "DESC",
        "LIMIT", "INSERT", "INTO", "VALUES", "UPDATE", "SET", "DELETE", "JOIN",
        "ON", "GROUP", "HAVING", "LEFT", "OUTER", "AS", "TRUE", "FALSE"
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd4, 3'd5, 3'd3, 3'd2, 3'd5, 3'd2, 3'd3, 3'd4,
        3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd3, 3'd6, 3'd4,
        3'd2, 3'd5, 3'd6, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_text;
        logic [7:0]        text_byte;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    // first letter moves to the lowest byte, as the keyword buffer stores it
    function automatic logic [KW_BUF_W-1:0] kw_packed(input logic [KW_BUF_W-1:0] s,
                                                      input logic [2:0] len);
        logic [KW_BUF_W-1:0] p;
        p = '0;
        for (int i = 0; i < KW_MAX; i++) begin
            if (i < int'(len)) begin
                p[8*i +: 8] = s[8*(int'(len) - 1 - i) +: 8];
            end
        end
        return p;
    endfunction

    function automatic logic [KIND_W-1:0] kw_lookup(input logic [KW_BUF_W-1:0] buf_val,
                                                    input logic [2:0] len);
        logic [KIND_W-1:0] kind;
        kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (len == KW_LEN[k] && buf_val == kw_packed(KW_STR[k], KW_LEN[k])) begin
                kind = K_KW0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

endpackage

// File: design/sqltl_if.sv
// ----------------------------------------------------------------------------
// sqltl_in_if / sqltl_out_if
// Valid/ready channels carrying text bytes in and token results out.
// ----------------------------------------------------------------------------
interface sqltl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, output char_byte, output end_of_text, input ready);
    modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface sqltl_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] token_kind;
    logic       is_text;
    logic [7:0] text_byte;
    logic       last_of_run;

    modport source (output valid, output token_kind, output is_text, output text_byte,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input is_text, input text_byte,
                  input last_of_run, output ready);
endinterface

// File: design/sqltl_step.sv
// ----------------------------------------------------------------------------
// sqltl_step
// Input register, scanner state and per-byte result formation.
// ----------------------------------------------------------------------------
module sqltl_step
    import sqltl_pkg::*;
#(
    parameter int MAX_TEXT = 32
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_eot,
    input  logic       room,
    output push_t      push
);
    localparam int CW = $clog2(MAX_TEXT);
    localparam logic [CW-1:0] TEXT_LIM = CW'(MAX_TEXT - 1);

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUM_INT, MODE_NUM_FRAC, MODE_STRING,
        MODE_STR_QUOTE, MODE_LT, MODE_GT, MODE_BANG, MODE_MINUS
    } mode_t;

    logic                valid_reg;
    logic [7:0]          char_reg;
    logic                eot_reg;
    mode_t               mode_reg, mode_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KW_BUF_W-1:0] kbuf_reg, kbuf_next;
    logic                overlong_reg, overlong_next;

    logic    adv;
    logic    is_dig, is_alp, is_spc, do_start, text_ok;
    logic [7:0] c, upc;
    result_t a0, a1;
    logic    a0_v, a1_v;

    assign adv      = valid_reg && room;
    assign in_ready = !valid_reg || room;

    assign c       = char_reg;
    assign upc     = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    assign is_dig  = c >= 8'h30 && c <= 8'h39;
    assign is_alp  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
    assign is_spc  = c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    assign text_ok = count_reg < TEXT_LIM;

    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        kbuf_next     = kbuf_reg;
        overlong_next = overlong_reg;
        do_start      = 1'b0;
        a0_v          = 1'b0;
        a1_v          = 1'b0;
        a0            = '0;
        a1            = '0;

        if (eot_reg)
        begin
            // close any pending token, then the end marker
            a0_v = 1'b1;
            unique case (mode_reg)
                MODE_IDENT:
                    a0.kind = (overlong_reg || count_reg > CW'(KW_MAX)) ? K_IDENT
                              : kw_lookup(kbuf_reg, count_reg[2:0]);
                MODE_NUM_INT, MODE_NUM_FRAC:  a0.kind = K_NUMBER;
                MODE_STRING, MODE_STR_QUOTE:  a0.kind = K_STRING;
                MODE_LT:                      a0.kind = K_LT;
                MODE_GT:                      a0.kind = K_GT;
                MODE_BANG, MODE_MINUS:        a0.kind = K_ERROR;
                default:                      a0_v = 1'b0;
            endcase
            a1_v          = 1'b1;
            a1.kind       = K_EOF;
            mode_next     = MODE_IDLE;
            count_next    = '0;
            kbuf_next     = '0;
            overlong_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alp || is_dig)
                    begin
                        if (!overlong_reg)
                        begin
                            if (count_reg >= CW'(KW_MAX))
                                overlong_next = 1'b1;
                            else
                                kbuf_next[8*count_reg[2:0] +: 8] = upc;
                        end
                        if (text_ok)
                        begin
                            a0_v = 1'b1; a0.kind = K_IDENT; a0.is_text = 1'b1; a0.text_byte = c;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        a0_v = 1'b1;
                        a0.kind = (overlong_reg || count_reg > CW'(KW_MAX)) ? K_IDENT
                                  : kw_lookup(kbuf_reg, count_reg[2:0]);
                        do_start = 1'b1;
                    end
                end
                MODE_NUM_INT, MODE_NUM_FRAC:
                begin
                    if (is_dig || (c == CH_DOT && mode_reg == MODE_NUM_INT))
                    begin
                        if (c == CH_DOT)
                            mode_next = MODE_NUM_FRAC;
                        if (text_ok)
                        begin
                            a0_v = 1'b1; a0.kind = K_NUMBER; a0.is_text = 1'b1; a0.text_byte = c;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        a0_v = 1'b1; a0.kind = K_NUMBER;
                        do_start = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE)
                        mode_next = MODE_STR_QUOTE;
                    else if (text_ok)
                    begin
                        a0_v = 1'b1; a0.kind = K_STRING; a0.is_text = 1'b1; a0.text_byte = c;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_STR_QUOTE:
                begin
                    if (c == CH_QUOTE)
                    begin
                        // doubled quote stands for one quote byte
                        mode_next = MODE_STRING;
                        if (text_ok)
                        begin
                            a0_v = 1'b1; a0.kind = K_STRING; a0.is_text = 1'b1; a0.text_byte = c;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        a0_v = 1'b1; a0.kind = K_STRING;
                        do_start = 1'b1;
                    end
                end
                MODE_LT:
                begin
                    a0_v = 1'b1;
                    mode_next = MODE_IDLE;
                    if (c == CH_EQ)
                        a0.kind = K_LE;
                    else if (c == CH_GT)
                        a0.kind = K_NE;
                    else
                    begin
                        a0.kind = K_LT; do_start = 1'b1;
                    end
                end
                MODE_GT:
                begin
                    a0_v = 1'b1;
                    mode_next = MODE_IDLE;
                    if (c == CH_EQ)
                        a0.kind = K_GE;
                    else
                    begin
                        a0.kind = K_GT; do_start = 1'b1;
                    end
                end
                MODE_BANG:
                begin
                    a0_v = 1'b1;
                    mode_next = MODE_IDLE;
                    if (c == CH_EQ)
                        a0.kind = K_NE;
                    else
                    begin
                        a0.kind = K_ERROR; do_start = 1'b1;
                    end
                end
                MODE_MINUS:
                begin
                    if (is_dig)
                    begin
                        // minus and first digit both go out as number text
                        mode_next     = MODE_NUM_INT;
                        kbuf_next     = '0;
                        overlong_next = 1'b0;
                        count_next    = CW'(2);
                        a0_v = 1'b1; a0.kind = K_NUMBER; a0.is_text = 1'b1; a0.text_byte = CH_MINUS;
                        a1_v = 1'b1; a1.kind = K_NUMBER; a1.is_text = 1'b1; a1.text_byte = c;
                    end
                    else
                    begin
                        a0_v = 1'b1; a0.kind = K_ERROR;
                        do_start = 1'b1;
                    end
                end
                default:
                    do_start = 1'b1;
            endcase

            if (do_start)
            begin
                mode_next = MODE_IDLE;
                if (is_spc)
                    a1_v = 1'b0;
                else if (is_dig || is_alp)
                begin
                    mode_next     = is_dig ? MODE_NUM_INT : MODE_IDENT;
                    count_next    = CW'(1);
                    kbuf_next     = is_dig ? '0 : {{(KW_BUF_W-8){1'b0}}, upc};
                    overlong_next = 1'b0;
                    a1_v = 1'b1; a1.kind = is_dig ? K_NUMBER : K_IDENT;
                    a1.is_text = 1'b1; a1.text_byte = c;
                end
                else
                begin
                    priority case (c)
                        CH_MINUS: mode_next = MODE_MINUS;
                        CH_QUOTE:
                        begin
                            mode_next     = MODE_STRING;
                            count_next    = '0;
                            kbuf_next     = '0;
                            overlong_next = 1'b0;
                        end
                        CH_BANG:   mode_next = MODE_BANG;
                        CH_LT:     mode_next = MODE_LT;
                        CH_GT:     mode_next = MODE_GT;
                        CH_STAR:   begin a1_v = 1'b1; a1.kind = K_STAR;   end
                        CH_COMMA:  begin a1_v = 1'b1; a1.kind = K_COMMA;  end
                        CH_LPAREN: begin a1_v = 1'b1; a1.kind = K_LPAREN; end
                        CH_RPAREN: begin a1_v = 1'b1; a1.kind = K_RPAREN; end
                        CH_SEMI:   begin a1_v = 1'b1; a1.kind = K_SEMI;   end
                        CH_DOT:    begin a1_v = 1'b1; a1.kind = K_DOT;    end
                        CH_EQ:     begin a1_v = 1'b1; a1.kind = K_EQ;     end
                        default:   begin a1_v = 1'b1; a1.kind = K_ERROR;  end
                    endcase
                end
            end
        end
    end

    // pack the results of this byte into the queue write
    always_comb
    begin
        push       = '0;
        push.count = adv ? ({1'b0, a0_v} + {1'b0, a1_v}) : 2'd0;
        if (a0_v)
        begin
            push.r0      = a0;
            push.r0.last = !a1_v;
            push.r1      = a1;
            push.r1.last = 1'b1;
        end
        else
        begin
            push.r0      = a1;
            push.r0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            mode_reg     <= MODE_IDLE;
            count_reg    <= '0;
            kbuf_reg     <= '0;
            overlong_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (adv)
            begin
                mode_reg     <= mode_next;
                count_reg    <= count_next;
                kbuf_reg     <= kbuf_next;
                overlong_reg <= overlong_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= in_char;
            eot_reg  <= in_eot;
        end
    end

endmodule

// File: design/sqltl_queue.sv
// ----------------------------------------------------------------------------
// sqltl_queue
// Four-entry result queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module sqltl_queue
    import sqltl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);
    result_t    entry_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] fill_reg, fill_next;
    logic       pop;

    assign room      = fill_reg <= 3'd2;
    assign out_valid = fill_reg != 3'd0;
    assign head      = entry_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign fill_next = fill_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_reg + push.count;
            rd_reg   <= rd_reg + {1'b0, pop};
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_reg] <= push.r0;
        if (push.count == 2'd2)
            entry_reg[wr_reg + 2'd1] <= push.r1;
    end

endmodule

// File: design/sql_token_lexer.sv
// ----------------------------------------------------------------------------
// sql_token_lexer
// Streaming SQL tokenizer: statement bytes in, token results out.
// ----------------------------------------------------------------------------
// Input channel in_ch takes one text byte per beat, or an end_of_text beat
// that closes any pending token and emits the eof token. Output channel
// out_ch gives results in order: identifier, number and string tokens first
// stream their text bytes (is_text = 1), then one completion result with
// the token kind; operators, errors and eof carry no text. last_of_run marks
// the last result caused by an input beat. A beat causes zero to two results.
// An accepted beat is held in the input register, its results are formed
// from it and written into the four-entry queue, and the queue head shows
// on out_ch directly.
// Throughput: one input beat per cycle as long as each beat makes at most one
// result and out_ch is not stalled; the output side moves one result per
// cycle, which sets the rate for beats that make two.
// Reset clears the scanner to idle and empties the queue. When the receiver
// stalls, results wait in the queue and in.ready drops once fewer than two
// queue entries are free while a beat waits in the input register, holding it.
// ----------------------------------------------------------------------------
module sql_token_lexer
    import sqltl_pkg::*;
#(
    parameter int MAX_TEXT = 32
)(
    input logic         clk,
    input logic         rst_n,
    sqltl_in_if.sink    in_ch,
    sqltl_out_if.source out_ch
);
    push_t   push;
    logic    room;
    result_t head;

    sqltl_step #(
        .MAX_TEXT (MAX_TEXT)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_char  (in_ch.char_byte),
        .in_eot   (in_ch.end_of_text),
        .room     (room),
        .push     (push)
    );

    sqltl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .head      (head)
    );

    assign out_ch.token_kind  = head.kind;
    assign out_ch.is_text     = head.is_text;
    assign out_ch.text_byte   = head.text_byte;
    assign out_ch.last_of_run = head.last;

endmodule
